FILE: src/voice_mix_adsr_envelope_macros.svh
// Assertion macros for the voice mixer with ADSR envelope.
// Each macro expects signals named clk and rst in the including module.
`ifndef VOICE_MIX_ADSR_ENVELOPE_MACROS_SVH
`define VOICE_MIX_ADSR_ENVELOPE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMAE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VMAE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vmae_pkg.sv
// Shared constants and register indexes for the voice mixer with ADSR envelope.
// No dependencies.
package vmae_pkg;

  localparam int CFG_W     = 24;             // length registers
  localparam int LEVEL_W   = 17;             // Q1.16 levels and gains
  localparam int FRAC_BITS = 16;
  localparam int OPA_W     = 24;             // multiplicand and divisor width
  localparam int PROD_W    = OPA_W + LEVEL_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] ONE_Q16 = LEVEL_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_t;

endpackage

FILE: src/voice_mix_adsr_envelope.sv
// One synthesizer voice: three-oscillator mix, velocity gain and linear ADSR envelope.
// Depends on vmae_pkg and voice_mix_adsr_envelope_macros.svh.
`include "voice_mix_adsr_envelope_macros.svh"

// The block takes one sample transaction at a time and returns one result for it.
// All arithmetic runs one bit per cycle: a shift-add multiplier and a restoring
// divider share one 41-bit shift register, and three divide-by-3 lanes run side by side.
// A sample whose envelope ramps (attack, decay or release) makes four 17-step passes
// through the shared multiplier/divider (envelope multiply, envelope divide, velocity
// multiply, envelope multiply); a sample in sustain, at the end of release or with the
// voice idle makes only the velocity and envelope multiply passes. Every sample also
// runs the SAMPLE_BITS-step divide-by-3. The result sits
// in an output register, so a new sample is accepted while the last result waits.
// The configuration port is always ready; write it only while no sample is in flight.
module voice_mix_adsr_envelope
  import vmae_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_BITS    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] osc_a_sample,
  input  logic signed [SAMPLE_BITS-1:0] osc_b_sample,
  input  logic signed [SAMPLE_BITS-1:0] osc_c_sample,
  input  logic                          gate,
  input  logic [LEVEL_W-1:0]            velocity_gain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] voice_sample,
  output logic [LEVEL_W-1:0]            envelope_level,
  output logic                          voice_active,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int CMP_W     = (AGE_BITS > CFG_W + 1) ? AGE_BITS : CFG_W + 1;
  localparam int MIX_W     = SAMPLE_BITS + 2;
  localparam int MAGP_W    = PROD_W - FRAC_BITS;
  localparam int STEPS_MAX = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
  localparam int STEP_W    = $clog2(STEPS_MAX);
  localparam int POS_LIM   = (2 ** (SAMPLE_BITS - 1)) - 1;
  localparam int NEG_LIM   = 2 ** (SAMPLE_BITS - 1);
  localparam logic [STEP_W-1:0] LAST_MUL  = STEP_W'(LEVEL_W - 1);
  localparam logic [STEP_W-1:0] LAST_DIV3 = STEP_W'(SAMPLE_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_EMUL, S_EDIV, S_DIV3, S_MIX, S_VSET, S_VMUL, S_FMUL, S_DONE
  } state_t;

  typedef enum logic [1:0] {ENV_ATTACK, ENV_DECAY, ENV_RELEASE} env_mode_t;

  // Saturate a product magnitude to the sample range for the given sign.
  function automatic logic [SAMPLE_BITS-1:0] sat_mag(input logic [MAGP_W-1:0] mag,
                                                     input logic neg);
    logic [MAGP_W-1:0] lim;
    lim = neg ? MAGP_W'(NEG_LIM) : MAGP_W'(POS_LIM);
    return SAMPLE_BITS'((mag > lim) ? lim : mag);
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]   attack_len;
  logic [CFG_W-1:0]   decay_len;
  logic [LEVEL_W-1:0] sustain;
  logic [CFG_W-1:0]   release_len;

  // Voice state.
  state_t              state;
  env_mode_t           env_mode;
  logic [STEP_W-1:0]   cnt;
  logic [AGE_BITS-1:0] sample_age;
  logic [AGE_BITS-1:0] release_start_age;
  logic                running;
  logic [LEVEL_W-1:0]  env_level;
  logic                gate_prev;
  logic                gate_l;

  // Datapath registers.
  logic [SAMPLE_BITS-1:0] smp_mag [3];
  logic                   smp_neg [3];
  logic [1:0]             rem3    [3];
  logic [LEVEL_W-1:0]     vel;
  logic [MIX_W-1:0]       mix;
  logic                   sign_neg;
  logic [OPA_W-1:0]       mcand;
  logic [OPA_W-1:0]       div_den;
  logic [PROD_W-1:0]      prod;

  logic [SAMPLE_BITS-1:0] osc_in [3];
  assign osc_in[0] = osc_a_sample;
  assign osc_in[1] = osc_b_sample;
  assign osc_in[2] = osc_c_sample;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Envelope phase decisions.
  logic [LEVEL_W-1:0]  s_eff;
  logic [CFG_W-1:0]    r_eff;
  logic [AGE_BITS-1:0] elapsed;
  logic [CMP_W-1:0]    age_c;
  logic [CMP_W-1:0]    attack_c;
  logic                in_attack;
  logic                in_decay;
  logic                rel_end;
  logic [OPA_W-1:0]    decay_off;

  always_comb begin
    s_eff     = (sustain > ONE_Q16) ? ONE_Q16 : sustain;
    r_eff     = (release_len == '0) ? CFG_W'(1) : release_len;
    elapsed   = AGE_BITS'(sample_age - release_start_age);
    age_c     = CMP_W'(sample_age);
    attack_c  = CMP_W'(attack_len);
    in_attack = age_c < attack_c;
    in_decay  = age_c < (attack_c + CMP_W'(decay_len));
    rel_end   = (s_eff == '0) || (CMP_W'(elapsed) >= CMP_W'(r_eff));
    decay_off = OPA_W'(age_c - attack_c);
  end

  // One shift-add multiply step and one restoring divide step on the shared register.
  logic [OPA_W:0]    mul_hi_sum;
  logic [PROD_W-1:0] mul_next;
  logic [OPA_W:0]    div_t;
  logic              div_ge;
  logic [OPA_W-1:0]  div_rem;
  logic [PROD_W-1:0] div_next;

  always_comb begin
    mul_hi_sum = {1'b0, prod[PROD_W-1:LEVEL_W]};
    if (prod[0]) begin
      mul_hi_sum = mul_hi_sum + {1'b0, mcand};
    end
    mul_next = {mul_hi_sum, prod[LEVEL_W-1:1]};

    div_t    = {prod[PROD_W-1:LEVEL_W], prod[LEVEL_W-1]};
    div_ge   = div_t >= {1'b0, div_den};
    div_rem  = div_ge ? OPA_W'(div_t - {1'b0, div_den}) : OPA_W'(div_t);
    div_next = {div_rem, prod[LEVEL_W-2:0], div_ge};
  end

  // Divide-by-3 lanes, one quotient bit per cycle, and the signed mix.
  logic [2:0]       lane_t   [3];
  logic             lane_ge  [3];
  logic [1:0]       lane_rem [3];
  logic [MIX_W-1:0] lane_val [3];
  logic [MIX_W-1:0] mix_sum;
  logic [MIX_W-1:0] mix_abs;

  always_comb begin
    mix_sum = '0;
    for (int i = 0; i < 3; i++) begin
      lane_t[i]   = {rem3[i], smp_mag[i][SAMPLE_BITS-1]};
      lane_ge[i]  = lane_t[i] >= 3'd3;
      lane_rem[i] = lane_ge[i] ? 2'(lane_t[i] - 3'd3) : lane_t[i][1:0];
      lane_val[i] = smp_neg[i] ? MIX_W'(~{2'b00, smp_mag[i]} + 1'b1)
                               : {2'b00, smp_mag[i]};
      mix_sum     = mix_sum + lane_val[i];
    end
    mix_abs = mix[MIX_W-1] ? MIX_W'(~mix + 1'b1) : mix;
  end

  logic [SAMPLE_BITS-1:0] fin_mag;
  logic [SAMPLE_BITS-1:0] fin_val;

  always_comb begin
    fin_mag = sat_mag(prod[PROD_W-1:FRAC_BITS], sign_neg);
    fin_val = sign_neg ? SAMPLE_BITS'(~fin_mag + 1'b1) : fin_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len        <= '0;
      decay_len         <= '0;
      sustain           <= ONE_Q16;
      release_len       <= CFG_W'(1);
      state             <= S_IDLE;
      cnt               <= '0;
      sample_age        <= '0;
      release_start_age <= '0;
      running           <= 1'b0;
      env_level         <= '0;
      gate_prev         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK:  attack_len  <= cfg_data;
          REG_DECAY:   decay_len   <= cfg_data;
          REG_SUSTAIN: sustain     <= cfg_data[LEVEL_W-1:0];
          REG_RELEASE: release_len <= cfg_data;
          default: ;
        endcase
      end

      // A result finishing in this cycle refills the output register itself.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // Gate edges, age advance and voice restart happen on acceptance.
            if (gate && !running) begin
              sample_age        <= '0;
              release_start_age <= '0;
              env_level         <= '0;
              running           <= 1'b1;
            end else begin
              sample_age <= AGE_BITS'(sample_age + 1'b1);
              if (gate_prev && !gate) begin
                release_start_age <= sample_age;
              end
            end
            gate_prev <= gate;
            gate_l    <= gate;
            vel       <= velocity_gain;
            for (int i = 0; i < 3; i++) begin
              smp_neg[i] <= osc_in[i][SAMPLE_BITS-1];
              smp_mag[i] <= osc_in[i][SAMPLE_BITS-1] ? SAMPLE_BITS'(~osc_in[i] + 1'b1)
                                                     : osc_in[i];
              rem3[i]    <= 2'd0;
            end
            cnt   <= '0;
            state <= S_CLASS;
          end
        end

        S_CLASS: begin
          state <= S_DIV3;
          if (running) begin
            if (gate_l) begin
              if (in_attack) begin
                env_mode <= ENV_ATTACK;
                mcand    <= OPA_W'(sample_age);
                prod     <= PROD_W'(ONE_Q16);
                div_den  <= OPA_W'(attack_len);
                state    <= S_EMUL;
              end else if (in_decay) begin
                env_mode <= ENV_DECAY;
                mcand    <= decay_off;
                prod     <= PROD_W'(ONE_Q16 - s_eff);
                div_den  <= OPA_W'(decay_len);
                state    <= S_EMUL;
              end else begin
                env_level <= s_eff;
              end
            end else if (rel_end) begin
              env_level <= '0;
              running   <= 1'b0;
            end else begin
              env_mode <= ENV_RELEASE;
              mcand    <= OPA_W'(elapsed);
              prod     <= PROD_W'(s_eff);
              div_den  <= OPA_W'(r_eff);
              state    <= S_EMUL;
            end
          end
        end

        S_EMUL: begin
          prod <= mul_next;
          if (cnt == LAST_MUL) begin
            cnt   <= '0;
            state <= S_EDIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_EDIV: begin
          prod <= div_next;
          if (cnt == LAST_MUL) begin
            cnt   <= '0;
            state <= S_DIV3;
            case (env_mode)
              ENV_ATTACK:  env_level <= div_next[LEVEL_W-1:0];
              ENV_DECAY:   env_level <= ONE_Q16 - div_next[LEVEL_W-1:0];
              ENV_RELEASE: env_level <= s_eff - div_next[LEVEL_W-1:0];
              default:     env_level <= '0;
            endcase
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_DIV3: begin
          for (int i = 0; i < 3; i++) begin
            rem3[i]    <= lane_rem[i];
            smp_mag[i] <= {smp_mag[i][SAMPLE_BITS-2:0], lane_ge[i]};
          end
          if (cnt == LAST_DIV3) begin
            cnt   <= '0;
            state <= S_MIX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_MIX: begin
          mix   <= mix_sum;
          state <= S_VSET;
        end

        S_VSET: begin
          mcand    <= OPA_W'(mix_abs);
          sign_neg <= mix[MIX_W-1];
          prod     <= PROD_W'(vel);
          state    <= S_VMUL;
        end

        S_VMUL: begin
          if (cnt == LAST_MUL) begin
            // The velocity-scaled sample becomes the multiplicand of the envelope pass.
            cnt   <= '0;
            mcand <= OPA_W'(sat_mag(mul_next[PROD_W-1:FRAC_BITS], sign_neg));
            prod  <= PROD_W'(env_level);
            state <= S_FMUL;
          end else begin
            prod <= mul_next;
            cnt  <= cnt + 1'b1;
          end
        end

        S_FMUL: begin
          prod <= mul_next;
          if (cnt == LAST_MUL) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            voice_sample   <= fin_val;
            envelope_level <= env_level;
            voice_active   <= running;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `VMAE_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
  `VMAE_ASSERT_IMP(a_env_in_range, 1'b1, env_level <= ONE_Q16, "envelope above one")
  `VMAE_ASSERT_IMP(a_idle_env_zero, !running, env_level == '0, "idle voice with nonzero level")
  `VMAE_ASSERT_IMP(a_div_rem_bound, state == S_EDIV, prod[PROD_W-1:LEVEL_W] < div_den, "divider remainder overflow")
  `VMAE_ASSERT_NXT(a_out_from_done, !out_valid && state != S_DONE, !out_valid, "result without completion")

endmodule
